/* src/run_level_last_encoder_macros.svh */
// ----------------------------------------------------------------------------
// Run-level-last encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RUN_LEVEL_LAST_ENCODER_MACROS_SVH
`define RUN_LEVEL_LAST_ENCODER_MACROS_SVH

// Implication or plain property, checked at every rising edge out of reset.
`define RLLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge out of reset.
`define RLLE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* src/rlle_pkg.sv */
// ----------------------------------------------------------------------------
// Run-level-last encoder package
// Field widths, coding constants and the result entry type.
// ----------------------------------------------------------------------------
package rlle_pkg;

  localparam int COEF_W   = 16;
  localparam int RUN_W    = 7;

  // Result queue: room for the two results of one coefficient plus slack.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  localparam logic [RUN_W-1:0] RUN_MAX   = 7'd127;
  localparam logic [RUN_W-1:0] EMPTY_RUN = 7'd64;

  typedef struct packed {
    logic [RUN_W-1:0]         run;
    logic signed [COEF_W-1:0] level;
    logic                     last;
    logic                     item_done;
  } result_t;

endpackage

/* src/run_level_last_encoder.sv */
// ----------------------------------------------------------------------------
// Run-level-last encoder
// Codes a block of scan-ordered coefficients as (run, level, last) triples.
// ----------------------------------------------------------------------------
// One coefficient is taken per clock unless a full result queue stalls the
// input. A coefficient goes into an input register, is coded from there once
// the queue has room, and its results (none, one or two) are written into a
// four-entry result queue that drives the output ports. The input side keeps
// taking a coefficient every cycle as long as the queue has room for two
// results; with the output side always ready the rate is one coefficient per
// cycle. Only the block's final coefficient can produce two results. Runs
// saturate at 127 for blocks longer than 128 coefficients; an all-zero block
// yields run 64, level 0, last 1.
`include "run_level_last_encoder_macros.svh"

module run_level_last_encoder #(
  parameter int BLOCK_COEFS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rlle_pkg::COEF_W-1:0]   coef,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [rlle_pkg::RUN_W-1:0]    run,
  output logic signed [rlle_pkg::COEF_W-1:0]   level,
  output logic                                 last,
  output logic                                 item_done
);

  localparam int POS_W = $clog2(BLOCK_COEFS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFS - 1);

  // input register
  logic                                s_valid;
  logic signed [rlle_pkg::COEF_W-1:0]  s_coef;

  // coding state
  logic [POS_W-1:0]                    position;
  logic [rlle_pkg::RUN_W-1:0]          zero_count;
  logic                                held_valid;
  logic [rlle_pkg::RUN_W-1:0]          held_run;
  logic signed [rlle_pkg::COEF_W-1:0]  held_level;

  // result queue
  rlle_pkg::result_t                   fifo_mem [rlle_pkg::FIFO_DEPTH];
  logic [rlle_pkg::PTR_W-1:0]          wr_ptr;
  logic [rlle_pkg::PTR_W-1:0]          rd_ptr;
  logic [rlle_pkg::CNT_W-1:0]          count;

  logic                                proc;
  logic                                nz;
  logic                                fin;
  logic                                push_held;
  logic                                push_fin;
  logic                                pop;
  logic [rlle_pkg::CNT_W-1:0]          push_n;
  logic                                hv_next;
  logic [rlle_pkg::RUN_W-1:0]          hr_next;
  logic signed [rlle_pkg::COEF_W-1:0]  hl_next;
  rlle_pkg::result_t                   res_held;
  rlle_pkg::result_t                   res_fin;
  rlle_pkg::result_t                   head;

  // Code the registered coefficient only when the queue can take two results.
  assign proc     = s_valid && (count <= rlle_pkg::CNT_W'(rlle_pkg::FIFO_DEPTH - 2));
  assign in_ready = !s_valid || proc;

  assign nz  = (s_coef != '0);
  assign fin = (position == LAST_POS);

  assign push_held = proc && nz && held_valid;
  assign push_fin  = proc && fin;
  assign push_n    = rlle_pkg::CNT_W'(push_held) + rlle_pkg::CNT_W'(push_fin);

  assign hv_next = held_valid || nz;
  assign hr_next = nz ? zero_count : held_run;
  assign hl_next = nz ? s_coef : held_level;

  always_comb begin
    res_held.run       = held_run;
    res_held.level     = held_level;
    res_held.last      = 1'b0;
    res_held.item_done = !fin;
    if (hv_next) begin
      res_fin.run   = hr_next;
      res_fin.level = hl_next;
    end else begin
      res_fin.run   = rlle_pkg::EMPTY_RUN;
      res_fin.level = '0;
    end
    res_fin.last      = 1'b1;
    res_fin.item_done = 1'b1;
  end

  assign head      = fifo_mem[rd_ptr];
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign run       = head.run;
  assign level     = head.level;
  assign last      = head.last;
  assign item_done = head.item_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s_coef <= coef;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      zero_count <= '0;
      held_valid <= 1'b0;
      held_run   <= '0;
      held_level <= '0;
    end else if (proc) begin
      if (fin) begin
        // close the block and start over
        position   <= '0;
        zero_count <= '0;
        held_valid <= 1'b0;
        held_run   <= '0;
        held_level <= '0;
      end else begin
        position   <= position + POS_W'(1);
        held_valid <= hv_next;
        held_run   <= hr_next;
        held_level <= hl_next;
        if (nz) begin
          zero_count <= '0;
        end else if (zero_count != rlle_pkg::RUN_MAX) begin
          zero_count <= zero_count + rlle_pkg::RUN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_held) begin
      fifo_mem[wr_ptr] <= res_held;
    end
    if (push_fin) begin
      fifo_mem[wr_ptr + rlle_pkg::PTR_W'(push_held)] <= res_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rlle_pkg::PTR_W'(push_n);
      rd_ptr <= rd_ptr + rlle_pkg::PTR_W'(pop);
      count  <= count + push_n - rlle_pkg::CNT_W'(pop);
    end
  end

  `RLLE_ASSERT_NEVER(a_count_in_range, count > rlle_pkg::CNT_W'(rlle_pkg::FIFO_DEPTH), "result queue overflow")
  `RLLE_ASSERT(a_double_only_final, push_held && push_fin |-> fin && nz, "two results for a non-final coefficient")
  `RLLE_ASSERT(a_block_restart, proc && fin |=> position == '0 && !held_valid && zero_count == '0, "state not cleared after final coefficient")

endmodule

/* sim/run_level_last_encoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Run-level-last encoder testbench
// Streams 64-coefficient blocks (directed, then random block shapes) through
// the encoder with random stalls on both handshakes. A scoreboard codes each
// accepted coefficient itself and checks every output triple in order.
// ----------------------------------------------------------------------------
module run_level_last_encoder_tb;

  localparam int BLOCK_COEFS    = 64;
  localparam int TOTAL_COEFS    = 1550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int N_DIRECTED     = 20;

  typedef enum int {
    BLK_EMPTY,
    BLK_SINGLE,
    BLK_SPARSE,
    BLK_HALF,
    BLK_DENSE,
    BLK_TAIL
  } block_kind_t;

  // Codes accepted coefficients into expected triples and checks the output.
  class triple_checker_t;
    rlle_pkg::result_t                  expected_triples[$];
    int                                 errors;
    int                                 blk_len;
    int                                 position;
    logic [rlle_pkg::RUN_W-1:0]         zero_count;
    bit                                 held_valid;
    logic [rlle_pkg::RUN_W-1:0]         held_run;
    logic signed [rlle_pkg::COEF_W-1:0] held_level;

    function new(int len);
      blk_len = len;
      errors  = 0;
      clear_block();
    endfunction

    function void clear_block();
      position   = 0;
      zero_count = '0;
      held_valid = 1'b0;
      held_run   = '0;
      held_level = '0;
    endfunction

    function void note_coef(logic signed [rlle_pkg::COEF_W-1:0] c);
      bit                last_coef;
      rlle_pkg::result_t r;
      last_coef = (position + 1 >= blk_len);
      if (c != 0) begin
        // A new nonzero releases the held pair, never marked last; its item_done is clear only if the block ends here.
        if (held_valid) begin
          r = '{run: held_run, level: held_level, last: 1'b0, item_done: !last_coef};
          expected_triples.push_back(r);
        end
        held_valid = 1'b1;
        held_run   = zero_count;
        held_level = c;
        zero_count = '0;
      end else if (zero_count < rlle_pkg::RUN_MAX) begin
        zero_count++;
      end
      if (last_coef) begin
        if (held_valid)
          r = '{run: held_run, level: held_level, last: 1'b1, item_done: 1'b1};
        else
          r = '{run: rlle_pkg::EMPTY_RUN, level: '0, last: 1'b1, item_done: 1'b1};
        expected_triples.push_back(r);
        clear_block();
      end else begin
        position++;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_triple(logic [rlle_pkg::RUN_W-1:0] run_got,
                      logic signed [rlle_pkg::COEF_W-1:0] level_got,
                      logic last_got, logic done_got);
      rlle_pkg::result_t want;
      if (expected_triples.size() == 0) begin
        report($sformatf("triple (%0d, %0d, last=%0b) with nothing pending",
                         run_got, level_got, last_got));
      end else begin
        want = expected_triples.pop_front();
        if (run_got !== want.run)
          report($sformatf("run got %0d expected %0d", run_got, want.run));
        if (level_got !== want.level)
          report($sformatf("level got %0d expected %0d", level_got, $signed(want.level)));
        if (last_got !== want.last)
          report($sformatf("last got %0b expected %0b", last_got, want.last));
        if (done_got !== want.item_done)
          report($sformatf("item_done got %0b expected %0b", done_got, want.item_done));
      end
    endtask
  endclass

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [rlle_pkg::COEF_W-1:0] coef;
  logic                               out_valid;
  logic                               out_ready;
  logic [rlle_pkg::RUN_W-1:0]         run;
  logic signed [rlle_pkg::COEF_W-1:0] level;
  logic                               last;
  logic                               item_done;

  triple_checker_t sb;
  bit              quiet;
  int              gap_pct;
  int              ready_left;
  int              idle_cycles;

  run_level_last_encoder #(
    .BLOCK_COEFS(BLOCK_COEFS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .coef(coef),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .run(run),
    .level(level),
    .last(last),
    .item_done(item_done)
  );

  always #2 clk = ~clk;

  function automatic logic signed [rlle_pkg::COEF_W-1:0] rand_level();
    logic signed [rlle_pkg::COEF_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'sh7fff;
      1: v = 16'sh8000;
      2: v = 16'sd1;
      3: v = -16'sd1;
      4, 5: begin
        v = rlle_pkg::COEF_W'($urandom_range(1, 15));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: begin
        v = rlle_pkg::COEF_W'($urandom);
        if (v == 0) v = 16'sh1234;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [rlle_pkg::COEF_W-1:0] directed_coef(int i);
    case (i)
      0:  return 16'sh7fff;
      1:  return 16'sh8000;
      3:  return 16'sd1;
      4:  return -16'sd1;
      7:  return 16'sh5555;
      8:  return 16'shaaaa;
      14: return 16'sh00ff;
      15: return -16'sd256;
      16: return 16'sd2;
      18: return -16'sd2;
      19: return 16'sh4000;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [rlle_pkg::COEF_W-1:0] block_coef(block_kind_t kind,
                                                                    int idx, int spot);
    case (kind)
      BLK_EMPTY:  return '0;
      BLK_SINGLE: return (idx == spot) ? rand_level() : '0;
      BLK_SPARSE: return ($urandom_range(0, 7) == 0) ? rand_level() : '0;
      BLK_HALF:   return ($urandom_range(0, 1) == 0) ? rand_level() : '0;
      BLK_DENSE:  return rand_level();
      // long leading run, then a pair held into a nonzero final coefficient
      BLK_TAIL:   return (idx == spot || idx == BLOCK_COEFS - 1) ? rand_level() : '0;
      default:    return '0;
    endcase
  endfunction

  task automatic send_coef(logic signed [rlle_pkg::COEF_W-1:0] v);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    coef     <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_coef(v);
  endtask

  // Output side: random stall and ready bursts, always ready near the end.
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      ready_left = $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
      ready_left = $urandom_range(0, 60);
    end
  end

  // Check each output transfer; stop the run if transfers cease.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_triple(run, level, last, item_done);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    block_kind_t kind;
    int          spot;
    int          n_blocks;
    int          b;
    int          idx;
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    coef      = '0;
    out_ready = 1'b0;
    quiet     = 1'b0;
    gap_pct   = 10;
    sb        = new(BLOCK_COEFS);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First block: field extremes up front, then a long run into a nonzero final coefficient.
    for (idx = 0; idx < BLOCK_COEFS; idx++) begin
      if (idx < N_DIRECTED)
        send_coef(directed_coef(idx));
      else
        send_coef((idx == BLOCK_COEFS - 1) ? 16'sh8000 : 16'sh0000);
    end

    n_blocks = (TOTAL_COEFS + BLOCK_COEFS / 2) / BLOCK_COEFS;
    for (b = 1; b < n_blocks; b++) begin
      kind = (b == 1) ? BLK_EMPTY : block_kind_t'($urandom_range(BLK_EMPTY, BLK_TAIL));
      if (kind == BLK_TAIL)
        spot = $urandom_range(40, BLOCK_COEFS - 2);
      else
        spot = $urandom_range(0, BLOCK_COEFS - 1);
      quiet = (b >= n_blocks - 4);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        default: gap_pct = 25;
      endcase
      for (idx = 0; idx < BLOCK_COEFS; idx++)
        send_coef(block_coef(kind, idx, spot));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_triples.size() != 0) @(posedge clk);
    // catch any stray triple after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
